/* rtl/otb_pkg.sv */
// Shared constants, codes and types of the one-shot timer bank.
package otb_pkg;

	localparam int NumTimers = 16;
	localparam int SlotW     = (NumTimers > 1) ? $clog2(NumTimers) : 1;

	localparam int ActionW = 2;
	localparam int KeyW    = 4;
	localparam int TimeW   = 32;
	localparam int KindW   = 2;

	// command codes
	localparam logic [ActionW-1:0] ActTick   = 2'd0;
	localparam logic [ActionW-1:0] ActAdd    = 2'd1;
	localparam logic [ActionW-1:0] ActModify = 2'd2;
	localparam logic [ActionW-1:0] ActDelete = 2'd3;

	// result kinds
	localparam logic [KindW-1:0] KindStatus = 2'd0;
	localparam logic [KindW-1:0] KindFired  = 2'd1;
	localparam logic [KindW-1:0] KindDone   = 2'd2;

	typedef logic [TimeW-1:0] time_t;
	typedef logic [SlotW-1:0] slot_t;

	// operands for the shared adder; sub selects a - b (carry out = a >= b)
	typedef struct packed {
		time_t a;
		time_t b;
		logic  sub;
	} alu_req_t;

	typedef struct packed {
		time_t sum;
		logic  carry;
	} alu_rsp_t;

endpackage

/* rtl/otb_if.sv */
// Request and result channel interfaces of the one-shot timer bank.
interface otb_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [otb_pkg::ActionW-1:0] action;
	logic [otb_pkg::KeyW-1:0]    timer_key;
	logic [otb_pkg::TimeW-1:0]   time_value;
	logic                        enable_bit;

	modport source (output valid, action, timer_key, time_value, enable_bit, input ready);
	modport sink (input valid, action, timer_key, time_value, enable_bit, output ready);
endinterface

interface otb_res_if;
	logic                      valid;
	logic                      ready;
	logic [otb_pkg::KindW-1:0] result_kind;
	logic                      success;
	logic [otb_pkg::KeyW-1:0]  fired_key;
	logic                      last;

	modport source (output valid, result_kind, success, fired_key, last, input ready);
	modport sink (input valid, result_kind, success, fired_key, last, output ready);
endinterface

/* rtl/otb_alu.sv */
// Shared 32-bit add / compare unit of the one-shot timer bank.
module otb_alu (
	input  otb_pkg::alu_req_t req,
	output otb_pkg::alu_rsp_t rsp
);

	logic [otb_pkg::TimeW:0] full;

	// one adder: b is inverted with carry-in for subtract
	always_comb begin
		full = {1'b0, req.a} + {1'b0, req.b ^ {otb_pkg::TimeW{req.sub}}}
			+ {{otb_pkg::TimeW{1'b0}}, req.sub};
		rsp.sum   = full[otb_pkg::TimeW-1:0];
		rsp.carry = full[otb_pkg::TimeW];
	end

endmodule

/* rtl/one_shot_timer_bank.sv */
// Top level of the one-shot timer bank: sequencer, slot store and result register.
//
// Channels:
//   cmd (sink)   : one request per handshake: tick, add, modify or delete.
//   res (source) : add/modify/delete give one status result (last = 1). A tick
//                  gives one fired result per expired timer in ascending key
//                  order, then a done marker (last = 1).
// Timing:
//   One request at a time; cmd.ready is high only while idle. add/modify/delete:
//   status is loaded in StCmd once the result register is free. tick: the
//   accept, StTick to bump the count, then one slot per cycle over all
//   NumTimers slots unless a fired result waits on res.ready, then StDone for
//   the done marker. The scan rate is set by the single read port of the
//   expiry memory and the one shared adder/comparator.
// Stall:
//   A result register drives res; while res.ready is low the sequencer holds
//   on the pending result and loses nothing.
// Reset:
//   arst_n clears the tick count, present and enabled bits, the sequencer and
//   the result valid bit. Expiry entries are only used for present slots.
module one_shot_timer_bank (
	input  logic              clk,
	input  logic              arst_n,
	otb_cmd_if.sink           cmd,
	otb_res_if.source         res
);

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StCmd  = 3'd1;
	localparam logic [2:0] StTick = 3'd2;
	localparam logic [2:0] StScan = 3'd3;
	localparam logic [2:0] StDone = 3'd4;

	localparam otb_pkg::slot_t LastSlot = otb_pkg::SlotW'(otb_pkg::NumTimers - 1);

	logic [2:0] state_q;

	// latched request
	logic [otb_pkg::ActionW-1:0] act_q;
	logic [otb_pkg::KeyW-1:0]    key_q;
	otb_pkg::time_t              tval_q;
	logic                        en_q;

	otb_pkg::time_t              tick_q;
	logic [otb_pkg::NumTimers-1:0] present_q;
	logic [otb_pkg::NumTimers-1:0] enabled_q;

	// expiry store: one write port, one registered read port
	otb_pkg::time_t expiry_mem [otb_pkg::NumTimers];
	otb_pkg::time_t rd_data_q;
	otb_pkg::slot_t rd_addr;
	logic           wr_en;
	otb_pkg::slot_t wr_addr;
	otb_pkg::time_t wr_data;

	otb_pkg::slot_t cur_q;

	// result register
	logic                       res_valid_q;
	logic [otb_pkg::KindW-1:0]  res_kind_q;
	logic                       res_ok_q;
	logic [otb_pkg::KeyW-1:0]   res_key_q;
	logic                       res_last_q;

	otb_pkg::alu_req_t alu_req;
	otb_pkg::alu_rsp_t alu_rsp;

	logic           accept;
	logic           out_free;
	otb_pkg::slot_t cmd_slot;
	logic           key_in_range;
	logic           cmd_ok;
	logic           fire;
	logic           scan_step;

	otb_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign cmd.ready = (state_q == StIdle);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !res_valid_q || res.ready;

	assign res.valid       = res_valid_q;
	assign res.result_kind = res_kind_q;
	assign res.success     = res_ok_q;
	assign res.fired_key   = res_key_q;
	assign res.last        = res_last_q;

	assign cmd_slot     = otb_pkg::SlotW'(key_q);
	assign key_in_range = (32'(key_q) < otb_pkg::NumTimers);

	// shared unit: tick + 1, tick + delay, or tick - expiry for the compare
	always_comb begin
		alu_req.a   = tick_q;
		alu_req.b   = tval_q;
		alu_req.sub = 1'b0;
		case (state_q)
			StTick: begin
				alu_req.b = otb_pkg::TimeW'(1);
			end
			StScan: begin
				alu_req.b   = rd_data_q;
				alu_req.sub = 1'b1;
			end
			default: begin
				alu_req.b = tval_q;
			end
		endcase
	end

	// command outcome
	always_comb begin
		cmd_ok = 1'b0;
		if (key_in_range) begin
			case (act_q)
				otb_pkg::ActAdd:    cmd_ok = !present_q[cmd_slot];
				otb_pkg::ActModify: cmd_ok = present_q[cmd_slot];
				otb_pkg::ActDelete: cmd_ok = present_q[cmd_slot];
				default:            cmd_ok = 1'b0;
			endcase
		end
	end

	// scan: rd_data_q holds the expiry of cur_q
	assign fire      = present_q[cur_q] && enabled_q[cur_q] && alu_rsp.carry;
	assign scan_step = !fire || out_free;

	always_comb begin
		case (state_q)
			StTick:  rd_addr = '0;
			StScan:  rd_addr = scan_step ? cur_q + otb_pkg::SlotW'(1) : cur_q;
			default: rd_addr = cur_q;
		endcase
	end

	// memory write on a successful add or modify, when its status goes out
	always_comb begin
		wr_en   = (state_q == StCmd) && out_free && cmd_ok
			&& (act_q == otb_pkg::ActAdd || act_q == otb_pkg::ActModify);
		wr_addr = cmd_slot;
		wr_data = (act_q == otb_pkg::ActAdd) ? tval_q : alu_rsp.sum;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			expiry_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= expiry_mem[rd_addr];
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= cmd.action;
			key_q  <= cmd.timer_key;
			tval_q <= cmd.time_value;
			en_q   <= cmd.enable_bit;
		end
	end

	// sequencer and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			tick_q    <= '0;
			present_q <= '0;
			enabled_q <= '0;
			cur_q     <= '0;
		end else begin
			case (state_q)
				StIdle: begin
					if (accept) begin
						state_q <= (cmd.action == otb_pkg::ActTick) ? StTick : StCmd;
					end
				end
				StCmd: begin
					if (out_free) begin
						if (cmd_ok) begin
							case (act_q)
								otb_pkg::ActAdd: begin
									present_q[cmd_slot] <= 1'b1;
									enabled_q[cmd_slot] <= en_q;
								end
								otb_pkg::ActModify: begin
									enabled_q[cmd_slot] <= en_q;
								end
								otb_pkg::ActDelete: begin
									present_q[cmd_slot] <= 1'b0;
									enabled_q[cmd_slot] <= 1'b0;
								end
								default: begin
								end
							endcase
						end
						state_q <= StIdle;
					end
				end
				StTick: begin
					tick_q  <= alu_rsp.sum;
					cur_q   <= '0;
					state_q <= StScan;
				end
				StScan: begin
					if (scan_step) begin
						if (fire) begin
							enabled_q[cur_q] <= 1'b0;
						end
						if (cur_q == LastSlot) begin
							state_q <= StDone;
						end else begin
							cur_q <= cur_q + otb_pkg::SlotW'(1);
						end
					end
				end
				StDone: begin
					if (out_free) begin
						state_q <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= (state_q == StCmd) || (state_q == StDone)
				|| (state_q == StScan && fire);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				StCmd: begin
					res_kind_q <= otb_pkg::KindStatus;
					res_ok_q   <= cmd_ok;
					res_key_q  <= key_q;
					res_last_q <= 1'b1;
				end
				StScan: begin
					res_kind_q <= otb_pkg::KindFired;
					res_ok_q   <= 1'b0;
					res_key_q  <= otb_pkg::KeyW'(cur_q);
					res_last_q <= 1'b0;
				end
				default: begin
					res_kind_q <= otb_pkg::KindDone;
					res_ok_q   <= 1'b0;
					res_key_q  <= '0;
					res_last_q <= 1'b1;
				end
			endcase
		end
	end

endmodule
